// File: rtl/core/stsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stsa_pkg
// Shared types and constants of the sparse transpose scatter-accumulate unit:
// command codes, controller states, field widths and the control bundle that
// the controller hands to the datapath.
// ----------------------------------------------------------------------------
package stsa_pkg;

    // Field widths of one input beat and one result beat.
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 10;
    localparam int MAT_W   = 32;
    localparam int XV_W    = 32;
    localparam int VAL_W   = 48;
    localparam int PROD_W  = MAT_W + XV_W;
    localparam int FRAC_W  = 16;

    // Bit positions of the fields inside the slave-side tdata.
    localparam int IN_CMD_LO = 0;
    localparam int IN_IDX_LO = IN_CMD_LO + CMD_W;
    localparam int IN_MAT_LO = IN_IDX_LO + IDX_W;
    localparam int IN_XV_LO  = IN_MAT_LO + MAT_W;
    localparam int IN_LD_LO  = IN_XV_LO + XV_W;
    localparam int IN_USED_W = IN_LD_LO + VAL_W;
    localparam int IN_DATA_W = ((IN_USED_W + 7) / 8) * 8;

    // Bit positions of the fields inside the master-side tdata.
    localparam int OUT_IDX_LO = 0;
    localparam int OUT_VAL_LO = OUT_IDX_LO + IDX_W;
    localparam int OUT_USED_W = OUT_VAL_LO + VAL_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // Command codes carried in the lowest bits of an input beat.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_ACC  = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_READ
    } t_state;

    // Strobes from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch index, range flag and product of the accepted beat
        logic load_wr;   // write the load value of the accepted beat
        logic rd_en;     // read the store entry of the accepted beat
        logic acc_wr;    // write back the saturated sum
        logic out_load;  // move the read entry into the output register
    } t_dp_ctl;

endpackage
`default_nettype wire

// File: rtl/core/sparse_transpose_scatter_accumulate_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_transpose_scatter_accumulate_unit
// Scatter-accumulate engine for b += A^T x: a result store of Q32.16 sums fed
// one command beat at a time.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one command per beat: load writes a store entry,
//   accumulate adds matrix_value * x_value (Q16.16, floored to Q32.16) into
//   the entry of column_index with 48-bit saturation, read returns an entry.
//   Only a read produces a beat on the master channel (index and value).
//   A load is written as it is accepted; an accumulate reads the store and
//   multiplies, then adds and writes back; a read loads the output register
//   from the registered store read. The store has a registered read port and
//   a single write port, and the engine handles one command at a time, so it
//   takes no new beat until an accumulate or a read is finished.
//   A finished read sits in the output register while the next commands are
//   accepted; a read that finds the register still full waits in the engine,
//   holding off the slave side, until the receiver takes the earlier result.
//   Reset clears the controller and the result-valid flag only; store entries
//   are undefined until loaded. Indexes at or beyond STORE_DEPTH are ignored
//   by load and accumulate and read back as zero.
// ----------------------------------------------------------------------------
module sparse_transpose_scatter_accumulate_unit #(
    parameter int STORE_DEPTH = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // command, column_index, matrix_value, x_value, load_value (from bit 0)
    input  wire logic [stsa_pkg::IN_DATA_W-1:0]      s_tdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // read_index, read_value (from bit 0)
    output logic      [stsa_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready
);

    stsa_pkg::t_dp_ctl              ctl;
    logic [stsa_pkg::IDX_W-1:0]     read_index;
    logic [stsa_pkg::VAL_W-1:0]     read_value;

    stsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_cmd      (s_tdata[stsa_pkg::IN_CMD_LO +: stsa_pkg::CMD_W]),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_ctl      (ctl)
    );

    stsa_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_ctl          (ctl),
        .i_index        (s_tdata[stsa_pkg::IN_IDX_LO +: stsa_pkg::IDX_W]),
        .i_matrix_value (s_tdata[stsa_pkg::IN_MAT_LO +: stsa_pkg::MAT_W]),
        .i_x_value      (s_tdata[stsa_pkg::IN_XV_LO  +: stsa_pkg::XV_W]),
        .i_load_value   (s_tdata[stsa_pkg::IN_LD_LO  +: stsa_pkg::VAL_W]),
        .o_read_index   (read_index),
        .o_read_value   (read_value)
    );

    assign m_tdata = stsa_pkg::OUT_DATA_W'({read_value, read_index});

    // An accumulate write-back never coincides with a cycle open to new beats.
    a_acc_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> !ctl.acc_wr)
        else $error("accumulate write-back while slave side ready");

    // Every accepted accumulate raises the write-back strobe on the following cycle.
    a_acc_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready &&
         s_tdata[stsa_pkg::IN_CMD_LO +: stsa_pkg::CMD_W] == stsa_pkg::CMD_ACC)
        |=> ctl.acc_wr)
        else $error("accumulate not written back");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while full");

    // At most one store write or output load per cycle.
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({ctl.load_wr, ctl.acc_wr, ctl.out_load}))
        else $error("conflicting datapath strobes");

endmodule
`default_nettype wire

// File: rtl/core/stsa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stsa_ctrl
// Controller of the scatter-accumulate unit. Sequences one command at a time
// through the datapath and owns the result-valid flag of the master side.
// ----------------------------------------------------------------------------
module stsa_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    input  wire logic [stsa_pkg::CMD_W-1:0]   i_cmd,
    output logic                              o_s_tready,
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output stsa_pkg::t_dp_ctl                 o_ctl
);

    stsa_pkg::t_state r_state;
    stsa_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             accept;
    logic             out_free;

    assign o_s_tready = (r_state == stsa_pkg::ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            stsa_pkg::ST_IDLE: begin
                if (accept) begin
                    case (stsa_pkg::t_cmd'(i_cmd))
                        stsa_pkg::CMD_ACC:  n_state = stsa_pkg::ST_ACC;
                        stsa_pkg::CMD_READ: n_state = stsa_pkg::ST_READ;
                        default:            n_state = stsa_pkg::ST_IDLE;
                    endcase
                end
            end
            stsa_pkg::ST_ACC: begin
                n_state = stsa_pkg::ST_IDLE;
            end
            stsa_pkg::ST_READ: begin
                if (out_free) begin
                    n_state = stsa_pkg::ST_IDLE;
                end
            end
            default: n_state = stsa_pkg::ST_IDLE;
        endcase
    end

    // Datapath strobes.
    always_comb begin
        o_ctl = '0;
        case (r_state)
            stsa_pkg::ST_IDLE: begin
                if (accept) begin
                    o_ctl.capture = 1'b1;
                    case (stsa_pkg::t_cmd'(i_cmd))
                        stsa_pkg::CMD_LOAD: o_ctl.load_wr = 1'b1;
                        stsa_pkg::CMD_ACC:  o_ctl.rd_en   = 1'b1;
                        stsa_pkg::CMD_READ: o_ctl.rd_en   = 1'b1;
                        default:            o_ctl.rd_en   = 1'b0;
                    endcase
                end
            end
            stsa_pkg::ST_ACC: begin
                o_ctl.acc_wr = 1'b1;
            end
            stsa_pkg::ST_READ: begin
                o_ctl.out_load = out_free;
            end
            default: o_ctl = '0;
        endcase
    end

    // Result-valid flag: set when a result is loaded, cleared when taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctl.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stsa_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule
`default_nettype wire

// File: rtl/core/stsa_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stsa_dp
// Datapath of the scatter-accumulate unit: result store with one write and
// one registered read port, Q16.16 multiplier, saturating 48-bit adder and
// the output register.
// ----------------------------------------------------------------------------
module stsa_dp #(
    parameter int STORE_DEPTH = 1024
) (
    input  wire logic                          i_clk,
    input  wire stsa_pkg::t_dp_ctl             i_ctl,
    input  wire logic [stsa_pkg::IDX_W-1:0]    i_index,
    input  wire logic [stsa_pkg::MAT_W-1:0]    i_matrix_value,
    input  wire logic [stsa_pkg::XV_W-1:0]     i_x_value,
    input  wire logic [stsa_pkg::VAL_W-1:0]    i_load_value,
    output logic      [stsa_pkg::IDX_W-1:0]    o_read_index,
    output logic      [stsa_pkg::VAL_W-1:0]    o_read_value
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = (AW > stsa_pkg::IDX_W) ? AW : stsa_pkg::IDX_W;
    localparam int VW = stsa_pkg::VAL_W;

    logic [VW-1:0]                r_mem [STORE_DEPTH];
    logic [VW-1:0]                r_rd_data;
    logic [stsa_pkg::PROD_W-1:0]  r_prod;
    logic [stsa_pkg::IDX_W-1:0]   r_index;
    logic                         r_in_range;
    logic [stsa_pkg::IDX_W-1:0]   r_out_index;
    logic [VW-1:0]                r_out_value;

    logic [CW:0]                  idx_ext;
    logic                         in_range;
    logic [AW-1:0]                in_addr;
    logic [AW-1:0]                acc_addr;
    logic [AW-1:0]                wr_addr;
    logic [VW-1:0]                wr_data;
    logic                         wr_en;
    logic signed [VW-1:0]         prod_q;
    logic signed [VW:0]           sum;
    logic [VW-1:0]                sum_sat;
    logic [CW:0]                  acc_idx_ext;

    // Range check and store address of the beat on the slave side.
    assign idx_ext  = (CW+1)'(i_index);
    assign in_range = idx_ext < (CW+1)'(STORE_DEPTH);
    assign in_addr  = idx_ext[AW-1:0];

    assign acc_idx_ext = (CW+1)'(r_index);
    assign acc_addr    = acc_idx_ext[AW-1:0];

    // Capture of the accepted beat; the product is registered before the add.
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_index    <= i_index;
            r_in_range <= in_range;
            r_prod     <= stsa_pkg::PROD_W'($signed(i_matrix_value) * $signed(i_x_value));
        end
    end

    // Floor of the Q32.32 product to Q32.16 is the upper part of the word;
    // the product always fits in the PROD_W-bit word, so nothing is lost.
    assign prod_q = $signed(r_prod[stsa_pkg::PROD_W-1:stsa_pkg::FRAC_W]);

    // Saturating 48-bit sum of the stored entry and the product.
    assign sum = $signed({r_rd_data[VW-1], r_rd_data}) + $signed({prod_q[VW-1], prod_q});

    always_comb begin
        if (sum[VW] != sum[VW-1]) begin
            sum_sat = sum[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else begin
            sum_sat = sum[VW-1:0];
        end
    end

    // Single write port shared by loads and accumulate write-backs.
    assign wr_en   = (i_ctl.load_wr && in_range) || (i_ctl.acc_wr && r_in_range);
    assign wr_addr = i_ctl.acc_wr ? acc_addr : in_addr;
    assign wr_data = i_ctl.acc_wr ? sum_sat : i_load_value;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[in_addr];
        end
    end

    // Output register; an index beyond the store reads as zero.
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_index <= r_index;
            r_out_value <= r_in_range ? r_rd_data : '0;
        end
    end

    assign o_read_index = r_out_index;
    assign o_read_value = r_out_value;

endmodule
`default_nettype wire

// File: dv/stsa_read_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsa_read_checker
// Watches both stream channels of the scatter-accumulate unit. Every accepted
// command beat is applied to a private copy of the result store, and each
// read queues the entry it should return. Result beats are compared field by
// field against the oldest queued entry, and each mismatch is counted.
// ----------------------------------------------------------------------------
module stsa_read_checker
    import stsa_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // command, column_index, matrix_value, x_value, load_value (from bit 0)
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    // read_index, read_value (from bit 0)
    input  wire logic [OUT_DATA_W-1:0] i_m_tdata,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_reads_checked
);

    // Limits of a 48-bit signed sum, held at product width for comparison.
    localparam logic signed [PROD_W-1:0] SUM_MAX = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
    localparam logic signed [PROD_W-1:0] SUM_MIN = -(64'sd1 <<< (VAL_W - 1));

    typedef struct packed {
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } t_read_beat;

    t_read_beat              expected_reads[$];
    logic signed [VAL_W-1:0] column_sum [STORE_DEPTH];

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_reads_checked = 0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            column_sum[i] = '0;
        end
    end

    // The exact Q32.32 product is floored to Q32.16, added, then clamped.
    function automatic logic signed [VAL_W-1:0] saturating_mac(
        input logic signed [VAL_W-1:0] base,
        input logic signed [MAT_W-1:0] mat,
        input logic signed [XV_W-1:0]  xv
    );
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] sum;
        prod = mat * xv;
        sum  = (prod >>> FRAC_W) + base;
        if (sum > SUM_MAX) begin
            sum = SUM_MAX;
        end else if (sum < SUM_MIN) begin
            sum = SUM_MIN;
        end
        return sum[VAL_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] checker: %s", $time, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_read_beat              want;
        t_read_beat              got;
        logic [CMD_W-1:0]        cmd;
        logic [IDX_W-1:0]        idx;
        logic signed [MAT_W-1:0] mat;
        logic signed [XV_W-1:0]  xv;
        logic signed [VAL_W-1:0] ld;
        if (i_rst_n) begin
            // Result side first: a beat leaving now never belongs to the
            // command beat accepted on the same edge.
            if (i_m_tvalid && i_m_tready) begin
                got.index = i_m_tdata[OUT_IDX_LO +: IDX_W];
                got.value = i_m_tdata[OUT_VAL_LO +: VAL_W];
                if (expected_reads.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing pending: index %0d value 0x%0h",
                                              got.index, got.value));
                end else begin
                    want = expected_reads.pop_front();
                    o_reads_checked++;
                    if (got.index !== want.index) begin
                        report_mismatch($sformatf("read_index expected %0d, got %0d",
                                                  want.index, got.index));
                    end
                    if (got.value !== want.value) begin
                        report_mismatch($sformatf("read_value of entry %0d expected 0x%0h, got 0x%0h",
                                                  want.index, want.value, got.value));
                    end
                end
            end

            // Command side: update the private store and queue reads.
            if (i_s_tvalid && i_s_tready) begin
                cmd = i_s_tdata[IN_CMD_LO +: CMD_W];
                idx = i_s_tdata[IN_IDX_LO +: IDX_W];
                mat = i_s_tdata[IN_MAT_LO +: MAT_W];
                xv  = i_s_tdata[IN_XV_LO  +: XV_W];
                ld  = i_s_tdata[IN_LD_LO  +: VAL_W];
                case (t_cmd'(cmd))
                    CMD_LOAD: begin
                        if (idx < STORE_DEPTH) begin
                            column_sum[idx] = ld;
                        end
                    end
                    CMD_ACC: begin
                        if (idx < STORE_DEPTH) begin
                            column_sum[idx] = saturating_mac(column_sum[idx], mat, xv);
                        end
                    end
                    CMD_READ: begin
                        want.index = idx;
                        want.value = (idx < STORE_DEPTH) ? column_sum[idx] : '0;
                        expected_reads.push_back(want);
                    end
                    default: begin
                        // The spare command code leaves everything untouched.
                    end
                endcase
            end
            o_pending = expected_reads.size();
        end
    end

endmodule

// File: dv/tb_sparse_transpose_scatter_accumulate_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_transpose_scatter_accumulate_unit
// Drives command beats into the scatter-accumulate unit and paces the result
// channel. A directed opening hits saturation at both ends, floor rounding of
// negative products, the extreme columns and the spare command code; random
// load/accumulate/read runs follow, with gaps and receiver stalls. The checker
// beside the unit does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_sparse_transpose_scatter_accumulate_unit;

    import stsa_pkg::*;

    localparam int               DEPTH        = 1024;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
    localparam int               RANDOM_ITEMS = 650;
    localparam int               CYCLE_LIMIT  = 400000;
    localparam int               DRAIN_CYCLES = 16;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [MAT_W-1:0] Q16_MAX = 32'h7FFF_FFFF;
    localparam logic [MAT_W-1:0] Q16_MIN = 32'h8000_0000;
    localparam logic [MAT_W-1:0] Q16_ONE = 32'h0001_0000;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;

    int fail_count;
    int pending_reads;
    int reads_checked;
    int cycle_count = 0;

    // Stimulus book-keeping: which columns hold a loaded value.
    bit loaded [DEPTH];
    int live_cols[$];
    int items_sent = 0;
    int cmd_seen [4] = '{0, 0, 0, 0};
    bit calm = 1'b0;
    int stall_left = 0;
    int rx_roll;

    sparse_transpose_scatter_accumulate_unit #(
        .STORE_DEPTH (DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    stsa_read_checker #(
        .STORE_DEPTH (DEPTH)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tdata       (s_tdata),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .o_fail_count    (fail_count),
        .o_pending       (pending_reads),
        .o_reads_checked (reads_checked)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reads still pending",
                     cycle_count, pending_reads);
            $display("tb_sparse_transpose_scatter_accumulate_unit: FAIL");
            $finish;
        end
    end

    // Receiver pacing: mostly ready, short stalls now and then, rare long ones.
    always @(posedge i_clk) begin
        if (calm) begin
            m_tready   <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 70) begin
                m_tready <= 1'b1;
            end else begin
                stall_left = (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                m_tready   <= 1'b0;
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Q16.16 operand: extremes, small magnitudes or anything at all.
    function automatic logic [MAT_W-1:0] rand_q16();
        int roll;
        logic [MAT_W-1:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            case ($urandom_range(0, 3))
                0: v = Q16_MAX;
                1: v = Q16_MIN;
                2: v = '0;
                default: v = '1;
            endcase
        end else if (roll < 50) begin
            v = $urandom_range(0, 1 << 18);
            if ($urandom_range(0, 1) == 1) begin
                v = -v;
            end
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    // Q32.16 load value: extremes, small magnitudes or full range.
    function automatic logic [VAL_W-1:0] rand_q32_16();
        int roll;
        logic [VAL_W-1:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            case ($urandom_range(0, 3))
                0: v = VAL_MAX;
                1: v = VAL_MIN;
                2: v = VAL_MAX - $urandom_range(0, 1 << 20);
                default: v = VAL_MIN + $urandom_range(0, 1 << 20);
            endcase
        end else if (roll < 40) begin
            v = VAL_W'($urandom_range(0, 1 << 24));
            if ($urandom_range(0, 1) == 1) begin
                v = -v;
            end
        end else begin
            v = VAL_W'({$urandom, $urandom});
        end
        return v;
    endfunction

    // Presents one command beat after a random gap and waits for acceptance.
    // Valid stays high afterwards so that back-to-back beats need no toggle.
    task automatic send_beat(
        input logic [CMD_W-1:0] cmd,
        input int               col,
        input logic [MAT_W-1:0] mat,
        input logic [XV_W-1:0]  xv,
        input logic [VAL_W-1:0] ld
    );
        logic [IN_DATA_W-1:0] beat;
        int gap;
        beat                         = '0;
        beat[IN_CMD_LO +: CMD_W]     = cmd;
        beat[IN_IDX_LO +: IDX_W]     = col[IDX_W-1:0];
        beat[IN_MAT_LO +: MAT_W]     = mat;
        beat[IN_XV_LO  +: XV_W]      = xv;
        beat[IN_LD_LO  +: VAL_W]     = ld;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (cmd == CMD_LOAD && !loaded[col]) begin
            loaded[col] = 1'b1;
            live_cols.push_back(col);
        end
        cmd_seen[cmd]++;
        items_sent++;
    endtask

    function automatic int pick_live_col(input int last_col);
        if (last_col >= 0 && loaded[last_col] && $urandom_range(0, 99) < 40) begin
            return last_col;
        end
        return live_cols[$urandom_range(0, live_cols.size() - 1)];
    endfunction

    initial begin : stimulus
        int last_col;
        int col;
        int roll;
        int run_len;
        int start_count;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: both saturation limits at the extreme columns.
        send_beat(CMD_LOAD, 0, '0, '0, VAL_MAX);
        send_beat(CMD_LOAD, DEPTH - 1, '0, '0, VAL_MIN);
        send_beat(CMD_READ, 0, '0, '0, '0);
        send_beat(CMD_READ, DEPTH - 1, '0, '0, '0);
        send_beat(CMD_ACC, 0, Q16_MAX, Q16_MAX, '0);
        send_beat(CMD_READ, 0, '0, '0, '0);
        send_beat(CMD_ACC, DEPTH - 1, Q16_MIN, Q16_MAX, '0);
        send_beat(CMD_READ, DEPTH - 1, '0, '0, '0);
        // Most negative times most negative, twice: the second one clips.
        send_beat(CMD_LOAD, 5, '0, '0, '0);
        send_beat(CMD_ACC, 5, Q16_MIN, Q16_MIN, '0);
        send_beat(CMD_ACC, 5, Q16_MIN, Q16_MIN, '0);
        send_beat(CMD_READ, 5, '0, '0, '0);
        // Tiny products: a negative one floors to minus one LSB, a positive to zero.
        send_beat(CMD_LOAD, 682, '0, '0, '0);
        send_beat(CMD_ACC, 682, '1, 32'h0000_0001, '0);
        send_beat(CMD_ACC, 682, 32'h0000_0001, 32'h0000_0001, '0);
        send_beat(CMD_READ, 682, '0, '0, '0);
        // Spare command code, then load followed at once by a read.
        send_beat(CMD_UNUSED, 341, $urandom, $urandom, VAL_W'({$urandom, $urandom}));
        send_beat(CMD_LOAD, 341, '0, '0, 48'hAAAA_5555_AAAA);
        send_beat(CMD_READ, 341, '0, '0, '0);
        send_beat(CMD_ACC, 341, Q16_ONE, -Q16_ONE, '0);
        send_beat(CMD_READ, 341, '0, '0, '0);
        send_beat(CMD_UNUSED, DEPTH - 1, '1, '1, '1);

        // Random part: occasional full column runs amid mixed traffic.
        start_count = items_sent;
        last_col    = -1;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            calm = (((items_sent - start_count) / 80) % 4) == 3;
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                // A full column run: load, one to six accumulates, read back.
                col = $urandom_range(0, DEPTH - 1);
                send_beat(CMD_LOAD, col, $urandom, $urandom, rand_q32_16());
                run_len = $urandom_range(1, 6);
                repeat (run_len) send_beat(CMD_ACC, col, rand_q16(), rand_q16(),
                                           VAL_W'({$urandom, $urandom}));
                send_beat(CMD_READ, col, $urandom, $urandom, VAL_W'({$urandom, $urandom}));
            end else if (live_cols.size() == 0 || roll < 28) begin
                col = $urandom_range(0, DEPTH - 1);
                send_beat(CMD_LOAD, col, $urandom, $urandom, rand_q32_16());
            end else if (roll < 72) begin
                col = pick_live_col(last_col);
                send_beat(CMD_ACC, col, rand_q16(), rand_q16(), VAL_W'({$urandom, $urandom}));
            end else if (roll < 95) begin
                col = pick_live_col(last_col);
                send_beat(CMD_READ, col, $urandom, $urandom, VAL_W'({$urandom, $urandom}));
            end else begin
                col = $urandom_range(0, DEPTH - 1);
                send_beat(CMD_UNUSED, col, $urandom, $urandom, VAL_W'({$urandom, $urandom}));
            end
            last_col = col;
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        // Let the checker see the last beat, wait for every pending read to
        // come back, then watch for strays.
        @(posedge i_clk);
        while (pending_reads != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d command beats: %0d loads, %0d accumulates, %0d reads, %0d spare.",
                 items_sent, cmd_seen[CMD_LOAD], cmd_seen[CMD_ACC], cmd_seen[CMD_READ],
                 cmd_seen[CMD_UNUSED]);
        $display("Checked %0d read beats across %0d loaded columns, %0d mismatches.",
                 reads_checked, live_cols.size(), fail_count);
        if (fail_count == 0) begin
            $display("tb_sparse_transpose_scatter_accumulate_unit: PASS");
        end else begin
            $display("tb_sparse_transpose_scatter_accumulate_unit: FAIL");
        end
        $finish;
    end

endmodule

// File: sparse_transpose_scatter_accumulate_unit.f
rtl/core/stsa_pkg.sv
rtl/core/stsa_ctrl.sv
rtl/core/stsa_dp.sv
rtl/core/sparse_transpose_scatter_accumulate_unit.sv
dv/stsa_read_checker.sv
dv/tb_sparse_transpose_scatter_accumulate_unit.sv
